FILE: hw/rtl/lattice_deposition_diffusion_step_macros.svh
// Assertion macros for the lattice deposition / diffusion step block.
// Included by the RTL files that carry concurrent assertions.
`ifndef LATTICE_DEPOSITION_DIFFUSION_STEP_MACROS_SVH
`define LATTICE_DEPOSITION_DIFFUSION_STEP_MACROS_SVH
`ifndef SYNTH
`define LDDS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define LDDS_NEVER(lbl, clk, rst_n, expr) \
	`LDDS_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define LDDS_ASSERT(lbl, clk, rst_n, prop)
`define LDDS_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: hw/rtl/ldds_pkg.sv
// Shared constants for the lattice deposition / diffusion step block.
// No dependencies.
`default_nettype none
package ldds_pkg;
	localparam int unsigned COORD_BITS  = 8;
	localparam int unsigned CELL_BITS   = 2 * COORD_BITS;
	localparam int unsigned CELLS       = 1 << CELL_BITS;
	localparam int unsigned HEIGHT_BITS = 8;
	localparam int unsigned COUNT_BITS  = CELL_BITS + 1;
	localparam int unsigned ACC_BITS    = 66;
	localparam logic [HEIGHT_BITS-1:0] HMAX = {HEIGHT_BITS{1'b1}};
	localparam logic [13:0] DRAW_SCALE = 14'd10000;
	localparam logic [1:0] DIR_ROW_INC = 2'd0;
	localparam logic [1:0] DIR_COL_DEC = 2'd1;
	localparam logic [1:0] DIR_ROW_DEC = 2'd2;
	localparam logic [1:0] DIR_COL_INC = 2'd3;
	localparam logic REG_FLUX = 1'b0;
	localparam logic REG_HOP  = 1'b1;
endpackage
`default_nettype wire

FILE: hw/rtl/ldds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ldds_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/lattice_deposition_diffusion_step.sv
// Top level of the lattice deposition / diffusion event engine.
// Depends on ldds_pkg, ldds_ram and lattice_deposition_diffusion_step_macros.svh.
//
// One event is accepted when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high and cannot be held
// off. After reset the height store is cleared, one site a cycle, so busy stays
// high until every site is cleared. An event runs the rate product and sum,
// a serial compare on the shared 66-bit adder, and for a hop a serial modulo
// on the same adder plus a walker lookup; then come the height and walker
// read-modify-writes and the done state. With no walkers a deposition skips
// the product, sum and compare. busy returns low after each event before the
// next one is accepted. The rate registers are read in the product and sum
// steps of an event, so write them only while no event is in flight.
`default_nettype none
`include "lattice_deposition_diffusion_step_macros.svh"
module lattice_deposition_diffusion_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [13:0] choice_draw,
	input  wire logic [7:0]  dep_row,
	input  wire logic [7:0]  dep_col,
	input  wire logic [15:0] walker_draw,
	input  wire logic [1:0]  hop_dir,
	output logic             done,
	output logic             event_kind,
	output logic [7:0]       from_row,
	output logic [7:0]       from_col,
	output logic [7:0]       to_row,
	output logic [7:0]       to_col,
	output logic [7:0]       to_height,
	output logic [16:0]      walker_count,
	output logic             height_saturated
);
	localparam int unsigned CB = ldds_pkg::CELL_BITS;
	localparam int unsigned HB = ldds_pkg::HEIGHT_BITS;
	localparam int unsigned NB = ldds_pkg::COUNT_BITS;
	localparam int unsigned AB = ldds_pkg::ACC_BITS;

	typedef enum logic [15:0] {
		S_CLEAR = 16'h0001,
		S_IDLE  = 16'h0002,
		S_MUL   = 16'h0004,
		S_SUM   = 16'h0008,
		S_CMP   = 16'h0010,
		S_MOD   = 16'h0020,
		S_WRD   = 16'h0040,
		S_WGET  = 16'h0080,
		S_HRD   = 16'h0100,
		S_HGET  = 16'h0200,
		S_RRD   = 16'h0400,
		S_RGET  = 16'h0800,
		S_RS    = 16'h1000,
		S_SRD   = 16'h2000,
		S_SGET  = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	state_t state_q, state_d;

	logic [31:0]   flux_q, hop_q;
	logic [NB-1:0] total_q;
	logic [CB-1:0] clr_q;
	logic [13:0]   draw_q;
	logic [15:0]   wdraw_q;
	logic [1:0]    dir_q;
	logic          kind_q, phase_q, ph_q, sat_q;
	logic [7:0]    fr_q, fc_q, tr_q, tc_q;
	logic [HB-1:0] toh_q;
	logic [48:0]   prod_q;
	logic [AB-1:0] acc_q, sop_q, dop_q;
	logic [3:0]    cnt_q;
	logic [NB-1:0] rem_q;
	logic [CB-1:0] rtgt_q, sl_q;

	// shared adder
	logic [AB-1:0] alu_a, alu_b, alu_sum;
	logic          alu_ci;
	logic [AB-1:0] rdep_ext;

	// memory ports
	logic          h_we, s_we, w_we;
	logic [CB-1:0] h_wa, h_ra, s_wa, s_ra, w_wa, w_ra;
	logic [HB-1:0] h_wd, h_rd;
	logic [CB-1:0] s_wd, s_rd, w_wd, w_rd;

	logic [CB-1:0] tsite, ssite;
	logic [NB-1:0] last;
	logic [7:0]    nr, nc;
	logic          finish_hop;

	assign tsite      = {tr_q, tc_q};
	assign ssite      = {fr_q, fc_q};
	assign last       = total_q - NB'(1);
	assign rdep_ext   = {18'd0, flux_q, 16'd0};
	assign finish_hop = kind_q && !phase_q;

	always_comb begin
		alu_a  = acc_q;
		alu_b  = sop_q;
		alu_ci = 1'b0;
		unique case (state_q)
			S_SUM: begin
				alu_a = rdep_ext;
				alu_b = {17'd0, prod_q};
			end
			S_CMP: begin
				if (ph_q) begin
					alu_b  = ~dop_q;
					alu_ci = 1'b1;
				end
			end
			S_MOD: begin
				alu_a  = {{(AB-NB){1'b0}}, rem_q[CB-1:0], wdraw_q[cnt_q]};
				alu_b  = ~{{(AB-NB){1'b0}}, total_q};
				alu_ci = 1'b1;
			end
			default: begin
			end
		endcase
		alu_sum = alu_a + alu_b + {{(AB-1){1'b0}}, alu_ci};
	end

	// neighbour of the hopping walker, wrapped on the torus
	always_comb begin
		nr = s_rd[15:8];
		nc = s_rd[7:0];
		case (dir_q)
			ldds_pkg::DIR_ROW_INC: nr = s_rd[15:8] + 8'd1;
			ldds_pkg::DIR_COL_DEC: nc = s_rd[7:0] - 8'd1;
			ldds_pkg::DIR_ROW_DEC: nr = s_rd[15:8] - 8'd1;
			default:               nc = s_rd[7:0] + 8'd1;
		endcase
	end

	always_comb begin
		h_we = 1'b0; h_wa = tsite; h_wd = h_rd + HB'(1); h_ra = tsite;
		s_we = 1'b0; s_wa = total_q[CB-1:0]; s_wd = tsite; s_ra = rem_q[CB-1:0];
		w_we = 1'b0; w_wa = tsite; w_wd = total_q[CB-1:0]; w_ra = rtgt_q;
		unique case (state_q)
			S_CLEAR: begin
				h_we = 1'b1;
				h_wa = clr_q;
				h_wd = '0;
			end
			S_HGET: begin
				if (h_rd != ldds_pkg::HMAX) begin
					h_we = 1'b1;
					if (h_rd == '0 && !total_q[NB-1]) begin
						s_we = 1'b1;
						w_we = 1'b1;
					end
				end
			end
			S_RGET: s_ra = last[CB-1:0];
			S_RS: begin
				s_we = 1'b1; s_wa = sl_q; s_wd = s_rd;
				w_we = 1'b1; w_wa = s_rd; w_wd = sl_q;
			end
			S_SRD: h_ra = ssite;
			S_SGET: begin
				h_wa = ssite;
				h_wd = h_rd - HB'(1);
				h_we = (h_rd != '0);
			end
			default: begin
			end
		endcase
	end

	ldds_ram #(.WIDTH(HB), .DEPTH(ldds_pkg::CELLS)) u_height (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
	);
	ldds_ram #(.WIDTH(CB), .DEPTH(ldds_pkg::CELLS)) u_sites (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
	);
	ldds_ram #(.WIDTH(CB), .DEPTH(ldds_pkg::CELLS)) u_slot (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == {CB{1'b1}}) state_d = S_IDLE;
			S_IDLE: begin
				if (start) state_d = (total_q == '0) ? S_HRD : S_MUL;
			end
			S_MUL: state_d = S_SUM;
			S_SUM: state_d = S_CMP;
			S_CMP: begin
				if (ph_q && cnt_q == 4'd13) state_d = alu_sum[AB-1] ? S_HRD : S_MOD;
			end
			S_MOD: if (cnt_q == 4'd0) state_d = S_WRD;
			S_WRD: state_d = S_WGET;
			S_WGET: state_d = S_HRD;
			S_HRD: state_d = S_HGET;
			S_HGET: begin
				if (h_rd == HB'(1)) state_d = S_RRD;
				else state_d = finish_hop ? S_SRD : S_DONE;
			end
			S_RRD: begin
				if (total_q == '0) state_d = finish_hop ? S_SRD : S_DONE;
				else state_d = S_RGET;
			end
			S_RGET: begin
				if ({1'b0, w_rd} >= total_q) state_d = finish_hop ? S_SRD : S_DONE;
				else state_d = S_RS;
			end
			S_RS: state_d = finish_hop ? S_SRD : S_DONE;
			S_SRD: state_d = S_SGET;
			S_SGET: state_d = S_RRD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			total_q <= '0;
			flux_q  <= 32'd65536;
			hop_q   <= 32'd65536;
			kind_q  <= 1'b0;
			phase_q <= 1'b0;
			ph_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_idx == ldds_pkg::REG_FLUX) flux_q <= cfg_data;
				else hop_q <= cfg_data;
			end
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + CB'(1);
				S_IDLE: begin
					kind_q  <= 1'b0;
					phase_q <= 1'b0;
				end
				S_SUM: begin
					ph_q  <= 1'b0;
					cnt_q <= '0;
				end
				S_CMP: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						cnt_q <= (cnt_q == 4'd13) ? 4'd15 : cnt_q + 4'd1;
						if (cnt_q == 4'd13 && !alu_sum[AB-1]) kind_q <= 1'b1;
					end
				end
				S_MOD: cnt_q <= cnt_q - 4'd1;
				S_HGET: begin
					if (h_rd != ldds_pkg::HMAX && h_rd == '0 && !total_q[NB-1])
						total_q <= total_q + NB'(1);
				end
				S_RS: total_q <= last;
				S_SGET: phase_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				draw_q  <= choice_draw;
				wdraw_q <= walker_draw;
				dir_q   <= hop_dir;
				fr_q    <= dep_row;
				fc_q    <= dep_col;
				tr_q    <= dep_row;
				tc_q    <= dep_col;
				sat_q   <= 1'b0;
			end
			S_MUL: prod_q <= {32'd0, total_q} * {17'd0, hop_q};
			S_SUM: begin
				sop_q <= alu_sum;
				dop_q <= rdep_ext;
				acc_q <= '0;
				rem_q <= '0;
			end
			S_CMP: begin
				if (!ph_q) begin
					if (draw_q[cnt_q]) acc_q <= alu_sum;
				end else begin
					if (ldds_pkg::DRAW_SCALE[cnt_q]) acc_q <= alu_sum;
					sop_q <= {sop_q[AB-2:0], 1'b0};
					dop_q <= {dop_q[AB-2:0], 1'b0};
				end
			end
			S_MOD: begin
				// restoring step: keep the trial only when it did not borrow
				if (!alu_sum[AB-1]) rem_q <= alu_sum[NB-1:0];
				else rem_q <= {rem_q[CB-1:0], wdraw_q[cnt_q]};
			end
			S_WGET: begin
				fr_q <= s_rd[15:8];
				fc_q <= s_rd[7:0];
				tr_q <= nr;
				tc_q <= nc;
			end
			S_HGET: begin
				rtgt_q <= tsite;
				if (h_rd == ldds_pkg::HMAX) begin
					sat_q <= 1'b1;
					toh_q <= h_rd;
				end else begin
					toh_q <= h_rd + HB'(1);
				end
			end
			S_RGET: sl_q <= w_rd;
			S_SGET: rtgt_q <= ssite;
			default: begin
			end
		endcase
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = (state_q == S_DONE);
	assign event_kind       = kind_q;
	assign from_row         = fr_q;
	assign from_col         = fc_q;
	assign to_row           = tr_q;
	assign to_col           = tc_q;
	assign to_height        = toh_q;
	assign walker_count     = total_q;
	assign height_saturated = sat_q;

	`LDDS_ASSERT(a_done_busy, clk, arst_n, done |-> busy)
	`LDDS_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	`LDDS_ASSERT(a_done_once, clk, arst_n, done |=> !done)
	`LDDS_NEVER(a_count_max, clk, arst_n, total_q > NB'(ldds_pkg::CELLS))
endmodule
`default_nettype wire
